[rtl/stf_pkg.sv]
// Package for the sequence-tagged FIFO: widths, request codes and the
// result record shared by the controller and the output buffer.
// No dependencies.
`timescale 1ns / 1ps

package stf_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned VALUE_W_DEF = 32;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned TOTAL_W   = 5;
  localparam int unsigned OCC_OUT_W = 5;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [TAG_W-1:0] SEQ_RESET = TAG_W'(1);
  localparam logic [TAG_W-1:0] SEQ_CLEAR = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_READ   = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_POP    = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_type_e;

  typedef struct packed {
    logic                 ok;
    logic [DATA_W-1:0]    value;
    logic [TAG_W-1:0]     tag;
    logic [OCC_OUT_W-1:0] occupancy;
    logic                 last;
  } rsp_t;

endpackage

[rtl/stf_if.sv]
// Channel interfaces of the sequence-tagged FIFO: request and result.
// Depends on stf_pkg.
`timescale 1ns / 1ps

interface stf_req_if;
  import stf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [DATA_W-1:0]         entry_value;
  logic signed [POS_W-1:0]   position;
  logic [TOTAL_W-1:0]        pop_total;
  logic                      pop_must;

  modport source (
    output valid, req_type, entry_value, position, pop_total, pop_must,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_value, position, pop_total, pop_must,
    output ready
  );
endinterface

interface stf_rsp_if;
  import stf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [DATA_W-1:0]    value_out;
  logic [TAG_W-1:0]     tag_out;
  logic [OCC_OUT_W-1:0] occupancy_out;
  logic                 last;

  modport source (
    output valid, ok, value_out, tag_out, occupancy_out, last,
    input  ready
  );
  modport sink (
    input  valid, ok, value_out, tag_out, occupancy_out, last,
    output ready
  );
endinterface

[rtl/stf_ring_mem.sv]
// Ring store of the FIFO: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module stf_ring_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write an entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read into the registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/stf_out_buf.sv]
// Two-entry result buffer that drives the result channel.
// Depends on stf_pkg and stf_rsp_if.
`timescale 1ns / 1ps

module stf_out_buf (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  stf_pkg::rsp_t push_data_i,
  output logic [1:0]  count_o,
  stf_rsp_if.source   rsp_o
);
  import stf_pkg::*;

  rsp_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  rsp_t       head;

  assign pop = rsp_o.valid && rsp_o.ready;

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  assign head                = ent_q[rd_q];
  assign rsp_o.valid         = (cnt_q != 2'd0);
  assign rsp_o.ok            = head.ok;
  assign rsp_o.value_out     = head.value;
  assign rsp_o.tag_out       = head.tag;
  assign rsp_o.occupancy_out = head.occupancy;
  assign rsp_o.last          = head.last;
  assign count_o             = cnt_q;

endmodule

[rtl/seq_tagged_fifo_with_index_read.sv]
// Sequence-tagged FIFO with indexed read: request decode, pointers, tag
// counter and the pop sequencer. Depends on stf_pkg, stf_if, stf_ring_mem
// and stf_out_buf.
//
// Usage:
//   req_i carries one request per transfer (append, read at a signed index,
//   peek front, batch pop, clear). rsp_o carries the results; every result
//   reports the occupancy after the whole request, and last marks the final
//   result of a request.
//   Append, clear, rejected and unknown requests: one result, written to the
//   output buffer in the cycle of the transfer, visible in the next cycle.
//   Read and peek: the result passes through the ring memory's read
//   register and then through the output buffer.
//   Batch pop of n entries: the transfer starts the pop sequencer, which
//   then issues one memory read per cycle while rsp_o is not stalled.
//   A new request is taken once the read data of the previous one has come
//   back and the two-entry output buffer has room: append, clear and
//   rejected requests can follow every cycle, a read or peek holds req_i
//   until its data is back and a pop until the sequencer is done.
//   Reset empties the FIFO and sets the tag counter to 1, so the first tag
//   handed out is 2. No clearing pass is needed. When rsp_o stalls, the
//   output buffer fills, the pop sequencer holds and req_i.ready drops.
`timescale 1ns / 1ps

module seq_tagged_fifo_with_index_read #(
  parameter int unsigned DEPTH       = stf_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = stf_pkg::VALUE_W_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stf_req_if.sink    req_i,
  stf_rsp_if.source  rsp_o
);
  import stf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned EW = TAG_W + VALUE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_e;

  // Wrap an offset from a ring slot
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        occ_q, occ_d;
  logic [TAG_W-1:0]     seq_q, seq_d;
  logic [RES_CNT_W-1:0] rem_q, rem_d;
  logic                 infl_q, infl_d;
  logic                 infl_tag_q, infl_tag_d;
  logic                 infl_last_q, infl_last_d;

  logic                   in_acc, deq;
  logic [1:0]             ob_count, cnt_eff;
  logic                   pop_space;
  req_type_e              req_e;
  logic [VALUE_WIDTH-1:0] val_w;
  logic                   app_ok;
  logic [XW-1:0]          occ_x, pos_u, back, rd_idx, total_x, pop_n;
  logic                   rd_ok, pop_ok;
  logic [AW-1:0]          rd_slot;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic push;
  rsp_t push_data;

  // Handshakes and buffer room
  assign in_acc    = req_i.valid && req_i.ready;
  assign deq       = rsp_o.valid && rsp_o.ready;
  assign cnt_eff   = ob_count - {1'b0, deq};
  assign pop_space = ({1'b0, cnt_eff} + {2'b00, infl_q}) <= 3'd1;
  assign req_i.ready = (state_q == S_IDLE) && !infl_q && (cnt_eff != 2'd2);

  // Decode the request fields
  assign req_e  = req_type_e'(req_i.req_type);
  assign val_w  = VALUE_WIDTH'(req_i.entry_value);
  assign occ_x  = XW'(occ_q);
  assign app_ok = (val_w != '0) && (occ_x < XW'(DEPTH));

  // Indexed read: front-relative or tail-relative
  assign pos_u  = {{(XW-POS_W){req_i.position[POS_W-1]}}, req_i.position};
  assign back   = XW'(0) - pos_u;
  assign rd_ok  = req_i.position[POS_W-1] ? (back <= occ_x) : (pos_u < occ_x);
  assign rd_idx = req_i.position[POS_W-1] ? (occ_x - back) : pos_u;
  assign rd_slot = ring_slot(front_q, rd_idx[AW-1:0]);

  // Batch pop size, limited by the fill and the result cap
  assign total_x = XW'(req_i.pop_total);
  assign pop_ok  = (total_x != '0) && (occ_x != '0) &&
                   !(req_i.pop_must && (occ_x < total_x));
  always_comb begin
    pop_n = (total_x < occ_x) ? total_x : occ_x;
    if (pop_n > XW'(MAX_RESULTS)) begin
      pop_n = XW'(MAX_RESULTS);
    end
  end

  assign mem_waddr = ring_slot(front_q, occ_q[AW-1:0]);
  assign mem_wdata = {seq_d, val_w};

  // Request decode and pop sequencer
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    occ_d       = occ_q;
    seq_d       = seq_q;
    rem_d       = rem_q;
    infl_d      = 1'b0;
    infl_tag_d  = infl_tag_q;
    infl_last_d = infl_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = front_q;
    push        = 1'b0;
    push_data   = '0;

    if (in_acc) begin
      push_data.last = 1'b1;
      unique case (req_e)
        REQ_APPEND: begin
          push = 1'b1;
          if (app_ok) begin
            seq_d         = seq_q + TAG_W'(1);
            occ_d         = occ_q + CW'(1);
            mem_we        = 1'b1;
            push_data.ok  = 1'b1;
            push_data.tag = seq_d;
          end
        end
        REQ_READ: begin
          if (rd_ok) begin
            mem_re      = 1'b1;
            mem_raddr   = rd_slot;
            infl_d      = 1'b1;
            infl_tag_d  = 1'b0;
            infl_last_d = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
        REQ_PEEK: begin
          if (occ_q != '0) begin
            mem_re      = 1'b1;
            infl_d      = 1'b1;
            infl_tag_d  = 1'b1;
            infl_last_d = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
        REQ_POP: begin
          if (pop_ok) begin
            state_d = S_POP;
            rem_d   = RES_CNT_W'(pop_n);
            occ_d   = occ_q - CW'(pop_n);
          end else begin
            push = 1'b1;
          end
        end
        REQ_CLEAR: begin
          push         = 1'b1;
          push_data.ok = 1'b1;
          front_d      = '0;
          occ_d        = '0;
          seq_d        = SEQ_CLEAR;
        end
        default: begin
          push = 1'b1;
        end
      endcase
      push_data.occupancy = OCC_OUT_W'(occ_d);
    end else if ((state_q == S_POP) && pop_space) begin
      // Issue one pop read and advance the front
      mem_re      = 1'b1;
      front_d     = ring_slot(front_q, AW'(1));
      rem_d       = rem_q - RES_CNT_W'(1);
      infl_d      = 1'b1;
      infl_tag_d  = 1'b1;
      infl_last_d = (rem_q == RES_CNT_W'(1));
      if (rem_q == RES_CNT_W'(1)) begin
        state_d = S_IDLE;
      end
    end

    // Return memory data as a result
    if (infl_q) begin
      push                = 1'b1;
      push_data.ok        = 1'b1;
      push_data.value     = DATA_W'(mem_rdata[VALUE_WIDTH-1:0]);
      push_data.tag       = infl_tag_q ? mem_rdata[EW-1:VALUE_WIDTH] : '0;
      push_data.occupancy = OCC_OUT_W'(occ_q);
      push_data.last      = infl_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      occ_q   <= '0;
      seq_q   <= SEQ_RESET;
      rem_q   <= '0;
      infl_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      seq_q   <= seq_d;
      rem_q   <= rem_d;
      infl_q  <= infl_d;
    end
  end

  // Hold result attributes of the read in flight
  always_ff @(posedge clk_i) begin
    infl_tag_q  <= infl_tag_d;
    infl_last_q <= infl_last_d;
  end

  stf_ring_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stf_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .count_o     (ob_count),
    .rsp_o       (rsp_o)
  );

  // An accepted append grows the fill by one
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_e == REQ_APPEND) && app_ok) |=> (occ_q == $past(occ_q) + CW'(1)))
    else $error("append did not grow the fill");

  // The pop sequencer always has entries left to read
  a_pop_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (rem_q != '0))
    else $error("pop sequencer active with nothing left");

  // A clear empties the ring and zeroes the tag counter
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_e == REQ_CLEAR)) |=> ((occ_q == '0) && (seq_q == SEQ_CLEAR)))
    else $error("clear left state behind");

  // Fill and front stay inside the ring
  a_ring_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q <= CW'(DEPTH)) && ({1'b0, front_q} < (AW+1)'(DEPTH)))
    else $error("ring pointer out of range");

endmodule
